// File: design/mrtc_pkg.sv
// Shared types and constants for the multi-robot transition conflict check.
`timescale 1ns / 1ps
`default_nettype none

package mrtc_pkg;

    localparam int ROBOTS      = 4;
    localparam int OTHERS      = 4;
    localparam int PATH_DEPTH  = 256;
    localparam int VERTEX_BITS = 8;
    localparam int LEN_REGS    = 4;

    localparam int POS_W      = 32;
    localparam int TS_W       = 16;
    localparam int T1_W       = TS_W + 1;
    localparam int STEP_W     = $clog2(PATH_DEPTH);
    localparam int LEN_W      = 9;
    localparam int PATH_IDX_W = $clog2(OTHERS);
    localparam int ROBOT_IDX_W = $clog2(ROBOTS);
    localparam int RCNT_W     = $clog2(ROBOTS + 1);
    localparam int OCNT_W     = $clog2(OTHERS + 1);
    localparam int ADDR_W     = PATH_IDX_W + STEP_W;
    localparam int STORE_DEPTH = OTHERS * PATH_DEPTH;
    localparam int KIND_W     = 3;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_ROBOTS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OTHERS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEN_A  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LEN_B  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LEN_C  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LEN_D  = 3'd5;

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    // conflict kinds
    localparam logic [KIND_W-1:0] KIND_NONE          = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INT_VERTEX    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PATH_VERTEX   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INT_SWAP      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PATH_SWAP     = 3'd4;

    typedef struct packed {
        logic                   func;
        logic [1:0]             path_select;
        logic [7:0]             step_index;
        logic [7:0]             vertex_value;
        logic [POS_W-1:0]       from_positions;
        logic [POS_W-1:0]       to_positions;
        logic [TS_W-1:0]        timestep;
    } t_in;

    typedef struct packed {
        logic                   transition_ok;
        logic [KIND_W-1:0]      conflict_kind;
        logic [1:0]             conflict_robot;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// File: design/multi_robot_transition_conflict_check_core.sv
// Top level: path store, per-path compare sequencer and conflict priority select.
// A write item is accepted while idle and yields no result.
// A check reads N stored paths and then registers its result, N being others_in_use
// saturated at 4 (no read with no paths in use): the sequencer reads one stored path
// per cycle through the store's two read ports. The next item is accepted once the result
// is registered. Reset (synchronous, active low) returns the control registers to their
// defaults; the path store is not cleared and holds undefined data until written.
`timescale 1ns / 1ps
`default_nettype none

module multi_robot_transition_conflict_check_core
    import mrtc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in                i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out                    o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    // configuration
    logic [2:0]       r_robots;
    logic [2:0]       r_others;
    logic [LEN_W-1:0] r_len [LEN_REGS];
    logic [REG_IDX_W-1:0] cfg_idx;
    logic             cfg_we;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_we  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_robots <= 3'(ROBOTS);
            r_others <= 3'd0;
            for (int k = 0; k < LEN_REGS; k++) begin
                r_len[k] <= LEN_W'(1);
            end
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_ROBOTS: r_robots <= pwdata[2:0];
                REG_OTHERS: r_others <= pwdata[2:0];
                REG_LEN_A:  r_len[0] <= pwdata[LEN_W-1:0];
                REG_LEN_B:  r_len[1] <= pwdata[LEN_W-1:0];
                REG_LEN_C:  r_len[2] <= pwdata[LEN_W-1:0];
                REG_LEN_D:  r_len[3] <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ROBOTS: prdata = PDATA_W'(r_robots);
            REG_OTHERS: prdata = PDATA_W'(r_others);
            REG_LEN_A:  prdata = PDATA_W'(r_len[0]);
            REG_LEN_B:  prdata = PDATA_W'(r_len[1]);
            REG_LEN_C:  prdata = PDATA_W'(r_len[2]);
            REG_LEN_D:  prdata = PDATA_W'(r_len[3]);
            default:    prdata = '0;
        endcase
    end

    // clamped counts
    logic [RCNT_W-1:0] nr_clamp;
    logic [OCNT_W-1:0] no_clamp;

    always_comb begin
        if (r_robots == 3'd0) begin
            nr_clamp = RCNT_W'(1);
        end else if (32'(r_robots) > ROBOTS) begin
            nr_clamp = RCNT_W'(ROBOTS);
        end else begin
            nr_clamp = RCNT_W'(r_robots);
        end
        if (32'(r_others) > OTHERS) begin
            no_clamp = OCNT_W'(OTHERS);
        end else begin
            no_clamp = OCNT_W'(r_others);
        end
    end

    // sequencer state
    t_state r_state, n_state;
    logic   in_acc, out_load;
    logic   chk_acc, wr_acc;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign chk_acc    = in_acc & (i_in_data.func == FUNC_CHECK);
    assign wr_acc     = in_acc & (i_in_data.func == FUNC_WRITE);

    // latched check operands
    logic [POS_W-1:0]      r_from, r_to;
    logic [TS_W-1:0]       r_ts;
    logic [T1_W-1:0]       r_t1;
    logic [RCNT_W-1:0]     r_nr;
    logic [OCNT_W-1:0]     r_no;
    logic [PATH_IDX_W-1:0] r_p;
    logic                  last_path;

    assign last_path = (OCNT_W'(r_p) + OCNT_W'(1)) == r_no;

    always_ff @(posedge i_clk) begin
        if (chk_acc) begin
            r_from <= i_in_data.from_positions;
            r_to   <= i_in_data.to_positions;
            r_ts   <= i_in_data.timestep;
            r_t1   <= T1_W'(i_in_data.timestep) + T1_W'(1);
            r_nr   <= nr_clamp;
            r_no   <= no_clamp;
        end
    end

    // effective length of the path being read and the store addresses
    logic [LEN_W-1:0]  len_eff, len_m1;
    logic              swap_ok;
    logic [STEP_W-1:0] idx_a;
    logic [ADDR_W-1:0] raddr_a, raddr_b;

    always_comb begin
        if (r_len[r_p] == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(r_len[r_p]) > PATH_DEPTH) begin
            len_eff = LEN_W'(PATH_DEPTH);
        end else begin
            len_eff = r_len[r_p];
        end
        len_m1  = len_eff - LEN_W'(1);
        swap_ok = T1_W'(len_eff) > r_t1;
        // past the path's end the final vertex stands
        idx_a   = swap_ok ? r_t1[STEP_W-1:0] : len_m1[STEP_W-1:0];
        raddr_a = {r_p, idx_a};
        raddr_b = {r_p, r_ts[STEP_W-1:0]};
    end

    logic [VERTEX_BITS-1:0] rdata_a, rdata_b;

    mrtc_ram #(
        .WIDTH (VERTEX_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (wr_acc),
        .i_waddr   ({i_in_data.path_select[PATH_IDX_W-1:0],
                     i_in_data.step_index[STEP_W-1:0]}),
        .i_wdata   (i_in_data.vertex_value[VERTEX_BITS-1:0]),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // per-robot unpacking and enables
    logic [VERTEX_BITS-1:0] from_v [ROBOTS];
    logic [VERTEX_BITS-1:0] to_v   [ROBOTS];
    logic [ROBOTS-1:0]      robot_en;

    always_comb begin
        for (int i = 0; i < ROBOTS; i++) begin
            from_v[i]   = r_from[i*VERTEX_BITS +: VERTEX_BITS];
            to_v[i]     = r_to[i*VERTEX_BITS +: VERTEX_BITS];
            robot_en[i] = RCNT_W'(i) < r_nr;
        end
    end

    // shared compare bank, one path per cycle, in the cycle after the read
    logic              r_cmp_vld, r_cmp_swap;
    logic [ROBOTS-1:0] r_pv, r_ps;
    logic [ROBOTS-1:0] vhit, shit;

    always_comb begin
        for (int i = 0; i < ROBOTS; i++) begin
            vhit[i] = robot_en[i] & (rdata_a == to_v[i]);
            shit[i] = robot_en[i] & r_cmp_swap & (to_v[i] == rdata_b)
                      & (from_v[i] == rdata_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= (r_state == ST_READ);
        end
        r_cmp_swap <= swap_ok;
        if (chk_acc) begin
            r_pv <= '0;
            r_ps <= '0;
        end else if (r_cmp_vld) begin
            r_pv <= r_pv | vhit;
            r_ps <= r_ps | shit;
        end
    end

    // internal checks and first-conflict select
    logic [ROBOTS-1:0]      iv, is_swap;
    logic                   found;
    logic [KIND_W-1:0]      kind;
    logic [ROBOT_IDX_W-1:0] who;
    t_out                   res;

    always_comb begin
        for (int i = 0; i < ROBOTS; i++) begin
            iv[i]      = 1'b0;
            is_swap[i] = 1'b0;
            for (int j = 0; j < ROBOTS; j++) begin
                if (j != i && robot_en[i] && robot_en[j] && to_v[j] == to_v[i]) begin
                    iv[i] = 1'b1;
                end
                if (j > i && robot_en[i] && robot_en[j] && to_v[i] == from_v[j]
                    && to_v[j] == from_v[i]) begin
                    is_swap[i] = 1'b1;
                end
            end
        end
        found = 1'b0;
        kind  = KIND_NONE;
        who   = '0;
        // vertex conflicts of all robots rank above any swap
        for (int i = 0; i < ROBOTS; i++) begin
            if (!found && (iv[i] || r_pv[i])) begin
                found = 1'b1;
                kind  = iv[i] ? KIND_INT_VERTEX : KIND_PATH_VERTEX;
                who   = ROBOT_IDX_W'(i);
            end
        end
        for (int i = 0; i < ROBOTS; i++) begin
            if (!found && (is_swap[i] || r_ps[i])) begin
                found = 1'b1;
                kind  = is_swap[i] ? KIND_INT_SWAP : KIND_PATH_SWAP;
                who   = ROBOT_IDX_W'(i);
            end
        end
        res.transition_ok  = ~found;
        res.conflict_kind  = kind;
        res.conflict_robot = 2'(who);
    end

    // sequencer
    assign out_load = (r_state == ST_FINISH) & (~o_out_valid | ~i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (chk_acc) begin
                    n_state = (no_clamp == '0) ? ST_FINISH : ST_READ;
                end
            end
            ST_READ: begin
                if (last_path) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_p     <= '0;
        end else begin
            r_state <= n_state;
            if (chk_acc) begin
                r_p <= '0;
            end else if (r_state == ST_READ) begin
                r_p <= r_p + PATH_IDX_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
        if (out_load) begin
            o_out_data <= res;
        end
    end

endmodule

`default_nettype wire

// File: design/mrtc_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module mrtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// File: design/mrtc_checker.sv
// Port-level assertions for the conflict check core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mrtc_checker
    import mrtc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire t_in                i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire t_out               o_out_data
);

    // a result waiting on a stalled sink stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // ok and conflict kind agree, robot index is zero on a clean move
    a_ok_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.transition_ok == (o_out_data.conflict_kind == KIND_NONE))
                        && (!o_out_data.transition_ok || o_out_data.conflict_robot == 2'd0))
        else $error("result fields inconsistent");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.conflict_kind <= KIND_PATH_SWAP)
        else $error("conflict kind out of range");

    // a check transfer occupies the block for at least the following cycle
    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.func == FUNC_CHECK |=> o_in_stall)
        else $error("check accepted without going busy");

    // a store write completes in its own cycle
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.func == FUNC_WRITE |=> !o_in_stall)
        else $error("write item stalled the input");

endmodule

bind multi_robot_transition_conflict_check_core mrtc_checker u_mrtc_checker (.*);

`default_nettype wire
